// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, stack cell moves and the result item layout.
// ----------------------------------------------------------------------------
package sme_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OPCODE_W = 4;
   localparam int unsigned REGIDX_W = 3;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NONE  = 4'd0,
      OP_PUSH  = 4'd1,
      OP_PUSHR = 4'd2,
      OP_POP   = 4'd3,
      OP_ADD   = 4'd4,
      OP_MUL   = 4'd5,
      OP_OUT   = 4'd6,
      OP_HALT  = 4'd7
   } opcode_type;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd5;

   // what a stack cell loads on the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ABOVE,
      CELL_BELOW
   } cell_op_type;

   typedef struct packed {
      logic               [DATA_W-1:0] out_value;
      logic                            out_valid;
      logic                            halted;
      logic             [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ===== rtl/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one decoded instruction per item on a shift-register operand stack and
// a small register file.
// ----------------------------------------------------------------------------
// Use: the req_ channel carries one instruction per item (opcode, immediate,
// register number); the rsp_ channel returns exactly one result item per
// instruction, in order. Both channels use valid/stall.
// Throughput: one item per cycle while the receiver does not stall. Every
// instruction reads only the top two cells of the stack chain and uses one
// register-file port, so each executes in the cycle it is accepted.
// The result item passes through the output register (or the skid entry) to rsp_.
// The stack is a chain of STACK_DEPTH cells; all but the top cell shift
// together. A value read from the register file lands in its read register
// and is treated as the top until the next stack move.
// Stall: an output register plus one skid entry sit behind the execution
// logic; req_stall rises only once the skid entry is occupied, i.e. after the
// receiver has held off while a second item was accepted.
// Reset: empties the stack, makes the registers read as zero, clears the halt
// flag and drops any pending result items. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
   parameter int STACK_DEPTH = 64,
   parameter int NUM_REGS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sme_pkg::OPCODE_W-1:0]      req_type,
   input  logic signed [sme_pkg::DATA_W-1:0] req_imm,
   input  logic [sme_pkg::REGIDX_W-1:0]      req_reg_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [sme_pkg::DATA_W-1:0] rsp_out_value,
   output logic                              rsp_out_valid,
   output logic                              rsp_halted,
   output logic [sme_pkg::STATUS_W-1:0]      rsp_status
);
   import sme_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int RIX_W  = IDX_W + REGIDX_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              halt_ff, halt_in;
   logic              fwd_ff, fwd_in;
   rsp_type           out_ff, skid_ff, res;
   logic              out_valid_ff, skid_valid_ff;

   logic              accept, take;
   logic [DATA_W-1:0] cell_val [STACK_DEPTH];
   cell_op_type       head_op, body_op;
   logic [DATA_W-1:0] head_in;
   logic [DATA_W-1:0] eff_top, opa, opb, arith;
   logic [DATA_W-1:0] rf_rd_data;
   logic              rf_rd_en, rf_wr_en;
   logic [RIX_W-1:0]  ri_ext;
   logic [IDX_W-1:0]  ri_idx;
   logic              ri_ok;
   logic              empty, full, two;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;

   assign ri_ext = RIX_W'(req_reg_index);
   assign ri_idx = ri_ext[IDX_W-1:0];
   assign ri_ok  = ri_ext < RIX_W'(NUM_REGS);

   assign empty = count_ff == '0;
   assign full  = count_ff == CNT_W'(STACK_DEPTH);
   assign two   = count_ff >= CNT_W'(2);

   // top of stack may still be waiting in the register-file read register
   assign eff_top = fwd_ff ? rf_rd_data : cell_val[0];
   assign opa     = empty ? '0 : eff_top;
   assign opb     = two ? cell_val[1] : '0;

   always_comb begin
      arith = (opcode_type'(req_type) == OP_MUL) ? DATA_W'(opa * opb) : opa + opb;
   end

   // decode and execute
   always_comb begin
      head_op        = CELL_HOLD;
      body_op        = CELL_HOLD;
      head_in        = req_imm;
      count_in       = count_ff;
      fwd_in         = fwd_ff;
      halt_in        = halt_ff;
      rf_rd_en       = 1'b0;
      rf_wr_en       = 1'b0;
      res.out_value  = '0;
      res.out_valid  = 1'b0;
      res.status     = ST_OK;
      if (halt_ff) begin
         res.status = ST_HALTED;
      end else begin
         unique case (opcode_type'(req_type)) inside
            OP_PUSH: begin
               if (full) begin
                  res.status = ST_OVER;
               end else if (accept) begin
                  head_op  = CELL_ABOVE;
                  body_op  = CELL_ABOVE;
                  count_in = count_ff + 1'b1;
                  fwd_in   = 1'b0;
               end
            end
            OP_PUSHR: begin
               if (full) begin
                  res.status = ST_OVER;
               end else if (accept) begin
                  body_op  = CELL_ABOVE;
                  count_in = count_ff + 1'b1;
                  fwd_in   = 1'b1;
                  rf_rd_en = 1'b1;
               end
            end
            OP_POP, OP_OUT: begin
               if (opcode_type'(req_type) == OP_OUT) begin
                  res.out_value = opa;
                  res.out_valid = 1'b1;
               end else begin
                  rf_wr_en = accept && ri_ok;
               end
               if (empty) begin
                  res.status = ST_UNDER;
               end else if (accept) begin
                  head_op  = CELL_BELOW;
                  body_op  = CELL_BELOW;
                  count_in = count_ff - 1'b1;
                  fwd_in   = 1'b0;
               end
            end
            OP_ADD, OP_MUL: begin
               head_in = arith;
               if (!two) begin
                  res.status = ST_UNDER;
               end
               if (accept) begin
                  head_op  = CELL_ABOVE;
                  body_op  = CELL_BELOW;
                  count_in = two ? count_ff - 1'b1 : CNT_W'(1);
                  fwd_in   = 1'b0;
               end
            end
            OP_HALT: begin
               halt_in = accept;
            end
            OP_NONE: begin
               res.status = ST_NONE;
            end
            default: begin
               res.status = ST_UNKNOWN;
            end
         endcase
      end
      res.halted = halt_ff || (opcode_type'(req_type) == OP_HALT);
   end

   // stack chain: cell 0 is the top
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] above, below;
      if (i == 0) begin : g_head
         assign above = head_in;
      end else if (i == 1) begin : g_second
         assign above = eff_top;
      end else begin : g_body
         assign above = cell_val[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_val[i];
      end else begin : g_mid
         assign below = cell_val[i+1];
      end
      sme_cell u_cell (
         .clock (clock),
         .op    ((i == 0) ? head_op : body_op),
         .above (above),
         .below (below),
         .value (cell_val[i])
      );
   end

   sme_regfile #(
      .NUM_REGS (NUM_REGS),
      .IDX_W    (IDX_W)
   ) u_regfile (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (rf_wr_en),
      .wr_idx      (ri_idx),
      .wr_data     (opa),
      .rd_en       (rf_rd_en),
      .rd_in_range (ri_ok),
      .rd_idx      (ri_idx),
      .rd_data     (rf_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         halt_ff       <= 1'b0;
         fwd_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            halt_ff  <= halt_in;
            fwd_ff   <= fwd_in;
         end
         if (!out_valid_ff || take) begin
            out_valid_ff  <= skid_valid_ff || accept;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_value = out_ff.out_value;
   assign rsp_out_valid = out_ff.out_valid;
   assign rsp_halted    = out_ff.halted;
   assign rsp_status    = out_ff.status;

endmodule

// ===== rtl/sme_cell.sv =====
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the operand stack; moves towards the top or the bottom, loads
// from its neighbour above or holds.
// ----------------------------------------------------------------------------
module sme_cell (
   input  logic                         clock,
   input  sme_pkg::cell_op_type         op,
   input  logic [sme_pkg::DATA_W-1:0]   above,
   input  logic [sme_pkg::DATA_W-1:0]   below,
   output logic [sme_pkg::DATA_W-1:0]   value
);
   import sme_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      case (op)
         CELL_ABOVE: value_in = above;
         CELL_BELOW: value_in = below;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/sme_regfile.sv =====
// ----------------------------------------------------------------------------
// Register file
// One write and one registered read port; entries never written read as zero.
// ----------------------------------------------------------------------------
module sme_regfile #(
   parameter int NUM_REGS = 8,
   parameter int IDX_W    = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [sme_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic                        rd_in_range,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [sme_pkg::DATA_W-1:0]  rd_data
);
   import sme_pkg::*;

   logic [DATA_W-1:0]   mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [DATA_W-1:0]   rd_mem_ff;
   logic                rd_hit_ff;
   logic                rd_hit;

   assign rd_hit = rd_in_range && valid_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff <= mem[rd_idx];
         rd_hit_ff <= rd_hit;
      end
   end

   assign rd_data = rd_hit_ff ? rd_mem_ff : '0;

endmodule

// ===== rtl/sme_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Port-level properties of the result items, bound to the top level.
// ----------------------------------------------------------------------------
module sme_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [sme_pkg::DATA_W-1:0] rsp_out_value,
   input logic                              rsp_out_valid,
   input logic                              rsp_halted,
   input logic [sme_pkg::STATUS_W-1:0]      rsp_status
);
   import sme_pkg::*;

   // only an out instruction carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_value == '0)
      else $error("result value set without out_valid");

   // an ignored item can only come after a halt
   a_ignored_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_HALTED |-> rsp_halted && !rsp_out_valid)
      else $error("ignored item reported while not halted");

   // out either succeeds or underflows
   a_out_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == ST_OK || rsp_status == ST_UNDER)
      else $error("out item with unexpected status");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_status))
      else $error("stalled result item changed");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_out_valid (rsp_out_valid),
   .rsp_halted    (rsp_halted),
   .rsp_status    (rsp_status)
);
